>>> hdl/mmts_pkg.sv
// Shared constants, codes and types of the min/max tracking stack.
package mmts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MAX  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MIN  = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RD_POS = 4'b0010,
        ST_RD_VAL = 4'b0100,
        ST_EXEC   = 4'b1000
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_pos;
        logic rd_val;
        logic commit;
    } cmd_t;

endpackage

>>> hdl/mmts_ctrl.sv
// Sequencer of the min/max tracking stack: handshakes and datapath commands.
module mmts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mmts_pkg::cmd_t cmd
);

    mmts_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_block;

    assign s_tready  = (state_reg == mmts_pkg::ST_IDLE);
    assign out_block = m_tvalid_reg && !m_tready;

    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.rd_pos  = (state_reg == mmts_pkg::ST_RD_POS);
    assign cmd.rd_val  = (state_reg == mmts_pkg::ST_RD_VAL);
    assign cmd.commit  = (state_reg == mmts_pkg::ST_EXEC) && !out_block;

    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mmts_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mmts_pkg::ST_RD_POS;
                end
            end
            mmts_pkg::ST_RD_POS: state_next = mmts_pkg::ST_RD_VAL;
            mmts_pkg::ST_RD_VAL: state_next = mmts_pkg::ST_EXEC;
            mmts_pkg::ST_EXEC: begin
                if (!out_block) begin
                    state_next = mmts_pkg::ST_IDLE;
                end
            end
            default: state_next = mmts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mmts_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> hdl/mmts_datapath.sv
// Value store, record stacks, counters and result register of the stack.
module mmts_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mmts_pkg::cmd_t                     cmd,
    input  logic [mmts_pkg::FUNC_W-1:0]        in_func,
    input  logic signed [mmts_pkg::DATA_W-1:0] in_value,
    output logic signed [mmts_pkg::DATA_W-1:0] read_value,
    output logic [mmts_pkg::STATUS_W-1:0]      status
);

    logic signed [mmts_pkg::DATA_W-1:0] value_mem [mmts_pkg::STACK_DEPTH];
    logic [mmts_pkg::ADDR_W-1:0]        max_pos_mem [mmts_pkg::STACK_DEPTH];
    logic [mmts_pkg::ADDR_W-1:0]        min_pos_mem [mmts_pkg::STACK_DEPTH];

    logic [mmts_pkg::CNT_W-1:0] depth_reg, depth_next;
    logic [mmts_pkg::CNT_W-1:0] max_cnt_reg, max_cnt_next;
    logic [mmts_pkg::CNT_W-1:0] min_cnt_reg, min_cnt_next;

    logic [mmts_pkg::FUNC_W-1:0]        func_reg;
    logic signed [mmts_pkg::DATA_W-1:0] val_reg;
    logic [mmts_pkg::ADDR_W-1:0]        max_pos_rd_reg, min_pos_rd_reg;
    logic signed [mmts_pkg::DATA_W-1:0] va_rd_reg, vb_rd_reg;
    logic signed [mmts_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic [mmts_pkg::STATUS_W-1:0]      status_reg, status_next;

    logic [mmts_pkg::CNT_W-1:0]  depth_dec, max_cnt_dec, min_cnt_dec;
    logic [mmts_pkg::ADDR_W-1:0] va_addr;
    logic depth_zero, depth_full;
    logic push_ok, max_push, min_push, max_drop, min_drop, pop_ok;

    assign depth_dec   = depth_reg - mmts_pkg::CNT_W'(1);
    assign max_cnt_dec = max_cnt_reg - mmts_pkg::CNT_W'(1);
    assign min_cnt_dec = min_cnt_reg - mmts_pkg::CNT_W'(1);
    assign depth_zero  = (depth_reg == '0);
    assign depth_full  = (depth_reg == mmts_pkg::CNT_W'(mmts_pkg::STACK_DEPTH));

    assign va_addr = (func_reg == mmts_pkg::FN_TOP) ? depth_dec[mmts_pkg::ADDR_W-1:0]
                                                    : max_pos_rd_reg;

    assign push_ok  = cmd.commit && (func_reg == mmts_pkg::FN_PUSH) && !depth_full;
    assign max_push = push_ok && (max_cnt_reg != mmts_pkg::CNT_W'(mmts_pkg::STACK_DEPTH))
                      && ((max_cnt_reg == '0) || (val_reg >= va_rd_reg));
    assign min_push = push_ok && (min_cnt_reg != mmts_pkg::CNT_W'(mmts_pkg::STACK_DEPTH))
                      && ((min_cnt_reg == '0) || (val_reg <= vb_rd_reg));
    assign pop_ok   = cmd.commit && (func_reg == mmts_pkg::FN_POP) && !depth_zero;
    assign max_drop = pop_ok && (max_cnt_reg != '0)
                      && (max_pos_rd_reg == depth_dec[mmts_pkg::ADDR_W-1:0]);
    assign min_drop = pop_ok && (min_cnt_reg != '0)
                      && (min_pos_rd_reg == depth_dec[mmts_pkg::ADDR_W-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= in_func;
            val_reg  <= in_value;
        end
        if (cmd.rd_pos) begin
            max_pos_rd_reg <= max_pos_mem[max_cnt_dec[mmts_pkg::ADDR_W-1:0]];
            min_pos_rd_reg <= min_pos_mem[min_cnt_dec[mmts_pkg::ADDR_W-1:0]];
        end
        if (cmd.rd_val) begin
            va_rd_reg <= value_mem[va_addr];
            vb_rd_reg <= value_mem[min_pos_rd_reg];
        end
        if (push_ok) begin
            value_mem[depth_reg[mmts_pkg::ADDR_W-1:0]] <= val_reg;
        end
        if (max_push) begin
            max_pos_mem[max_cnt_reg[mmts_pkg::ADDR_W-1:0]] <= depth_reg[mmts_pkg::ADDR_W-1:0];
        end
        if (min_push) begin
            min_pos_mem[min_cnt_reg[mmts_pkg::ADDR_W-1:0]] <= depth_reg[mmts_pkg::ADDR_W-1:0];
        end
        if (cmd.commit) begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        depth_next   = depth_reg;
        max_cnt_next = max_cnt_reg;
        min_cnt_next = min_cnt_reg;
        if (push_ok) begin
            depth_next = depth_reg + mmts_pkg::CNT_W'(1);
        end else if (pop_ok) begin
            depth_next = depth_dec;
        end
        if (max_push) begin
            max_cnt_next = max_cnt_reg + mmts_pkg::CNT_W'(1);
        end else if (max_drop) begin
            max_cnt_next = max_cnt_dec;
        end
        if (min_push) begin
            min_cnt_next = min_cnt_reg + mmts_pkg::CNT_W'(1);
        end else if (min_drop) begin
            min_cnt_next = min_cnt_dec;
        end
    end

    always_comb begin
        rdata_next  = '0;
        status_next = mmts_pkg::STS_OK;
        unique case (func_reg)
            mmts_pkg::FN_PUSH: begin
                if (depth_full) begin
                    status_next = mmts_pkg::STS_OVERFLOW;
                end
            end
            mmts_pkg::FN_POP: begin
                if (depth_zero) begin
                    status_next = mmts_pkg::STS_UNDERFLOW;
                end
            end
            mmts_pkg::FN_TOP, mmts_pkg::FN_MAX: begin
                if (depth_zero) begin
                    status_next = mmts_pkg::STS_EMPTY;
                end else begin
                    rdata_next = va_rd_reg;
                end
            end
            mmts_pkg::FN_MIN: begin
                if (depth_zero) begin
                    status_next = mmts_pkg::STS_EMPTY;
                end else begin
                    rdata_next = vb_rd_reg;
                end
            end
            default: begin
                rdata_next  = '0;
                status_next = mmts_pkg::STS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            max_cnt_reg <= '0;
            min_cnt_reg <= '0;
        end else begin
            depth_reg   <= depth_next;
            max_cnt_reg <= max_cnt_next;
            min_cnt_reg <= min_cnt_next;
        end
    end

    assign read_value = rdata_reg;
    assign status     = status_reg;

endmodule

>>> hdl/min_max_tracking_stack.sv
// Top level of the min/max tracking stack: sequencer, datapath and checks.
//
//  channel  | direction | tdata              | tuser
//  ---------+-----------+--------------------+-------------------
//  s_       | in        | [31:0] push_value  | [2:0] func
//  m_       | out       | [31:0] read_value  | [1:0] status
//
// Every request passes through accept, record position read, value read
// (both through registered memory ports), then commit of the result and state.
// A new request is accepted while the previous result still waits in m_.
// Commit holds while an earlier result sits unconsumed in the output register.
// Reset (aresetn low at a clock edge) empties the stack; no clearing pass.
module min_max_tracking_stack (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [7:0]  s_tuser,   // [2:0] func, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [7:0]  m_tuser    // [1:0] status, [7:2] zero
);

    mmts_pkg::cmd_t                     cmd;
    logic signed [mmts_pkg::DATA_W-1:0] read_value;
    logic [mmts_pkg::STATUS_W-1:0]      status;

    mmts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mmts_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_func    (s_tuser[mmts_pkg::FUNC_W-1:0]),
        .in_value   ($signed(s_tdata)),
        .read_value (read_value),
        .status     (status)
    );

    assign m_tdata = read_value;
    assign m_tuser = {{(8 - mmts_pkg::STATUS_W){1'b0}}, status};

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.rd_pos, cmd.rd_val, cmd.commit}))
        else $error("more than one datapath command at once");

    a_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.rd_pos ##1 cmd.rd_val)
        else $error("accepted transfer not followed by position and value reads");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("commit over a result not yet transferred");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while a request is in progress");

endmodule

>>> dv/min_max_tracking_stack_tb.sv
// Testbench for the min/max tracking stack: shadow-stack predictor, stream driver and monitor.
module min_max_tracking_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        wait_idle;
        logic [mmts_pkg::FUNC_W-1:0] func;
        logic [mmts_pkg::DATA_W-1:0] value;
    } stack_request_t;

    typedef struct packed {
        logic [mmts_pkg::DATA_W-1:0]   read_value;
        logic [mmts_pkg::STATUS_W-1:0] status;
    } stack_answer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [7:0]  m_tuser;

    stack_request_t requests_to_send[$];
    stack_answer_t  awaited_answers[$];
    stack_request_t in_flight;
    stack_answer_t  seen_answer;

    logic signed [mmts_pkg::DATA_W-1:0] shadow_values  [mmts_pkg::STACK_DEPTH];
    logic [mmts_pkg::ADDR_W-1:0]        shadow_max_pos [mmts_pkg::STACK_DEPTH];
    logic [mmts_pkg::ADDR_W-1:0]        shadow_min_pos [mmts_pkg::STACK_DEPTH];
    int shadow_depth   = 0;
    int shadow_max_cnt = 0;
    int shadow_min_cnt = 0;

    int gen_depth      = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int ready_cycle    = 0;
    int ready_mode     = 0;
    int mismatch_count = 0;

    min_max_tracking_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic logic signed [mmts_pkg::DATA_W-1:0] current_max();
        return shadow_values[shadow_max_pos[shadow_max_cnt-1]];
    endfunction

    function automatic logic signed [mmts_pkg::DATA_W-1:0] current_min();
        return shadow_values[shadow_min_pos[shadow_min_cnt-1]];
    endfunction

    function automatic stack_answer_t apply_request(stack_request_t req);
        stack_answer_t                      ans;
        logic signed [mmts_pkg::DATA_W-1:0] pushed;
        int                                 top_pos;
        ans.read_value = '0;
        ans.status     = mmts_pkg::STS_OK;
        pushed         = req.value;
        top_pos        = shadow_depth - 1;
        case (req.func)
            mmts_pkg::FN_PUSH: begin
                if (shadow_depth >= mmts_pkg::STACK_DEPTH) begin
                    ans.status = mmts_pkg::STS_OVERFLOW;
                end else begin
                    if (shadow_max_cnt == 0 || pushed >= current_max()) begin
                        shadow_max_pos[shadow_max_cnt] = mmts_pkg::ADDR_W'(shadow_depth);
                        shadow_max_cnt++;
                    end
                    if (shadow_min_cnt == 0 || pushed <= current_min()) begin
                        shadow_min_pos[shadow_min_cnt] = mmts_pkg::ADDR_W'(shadow_depth);
                        shadow_min_cnt++;
                    end
                    shadow_values[shadow_depth] = pushed;
                    shadow_depth++;
                end
            end
            mmts_pkg::FN_POP: begin
                if (shadow_depth == 0) begin
                    ans.status = mmts_pkg::STS_UNDERFLOW;
                end else begin
                    if (shadow_max_cnt > 0 &&
                        shadow_max_pos[shadow_max_cnt-1] == mmts_pkg::ADDR_W'(top_pos))
                        shadow_max_cnt--;
                    if (shadow_min_cnt > 0 &&
                        shadow_min_pos[shadow_min_cnt-1] == mmts_pkg::ADDR_W'(top_pos))
                        shadow_min_cnt--;
                    shadow_depth--;
                end
            end
            mmts_pkg::FN_TOP, mmts_pkg::FN_MAX, mmts_pkg::FN_MIN: begin
                if (shadow_depth == 0)
                    ans.status = mmts_pkg::STS_EMPTY;
                else if (req.func == mmts_pkg::FN_TOP)
                    ans.read_value = shadow_values[top_pos];
                else if (req.func == mmts_pkg::FN_MAX)
                    ans.read_value = current_max();
                else
                    ans.read_value = current_min();
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic logic [mmts_pkg::DATA_W-1:0] random_value();
        logic [mmts_pkg::DATA_W-1:0] one_hot;
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 4))
            0: return mmts_pkg::DATA_W'($signed($urandom_range(0, 6)) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            2: return $urandom_range(0, 1) ? one_hot : ~one_hot;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [mmts_pkg::FUNC_W-1:0] random_func(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return mmts_pkg::FN_PUSH;
        if (roll < push_pct + pop_pct)
            return mmts_pkg::FN_POP;
        if (roll < 97) begin
            case ($urandom_range(0, 2))
                0: return mmts_pkg::FN_TOP;
                1: return mmts_pkg::FN_MAX;
                default: return mmts_pkg::FN_MIN;
            endcase
        end
        return mmts_pkg::FUNC_W'($urandom_range(5, 7));
    endfunction

    task automatic add_request(logic [mmts_pkg::FUNC_W-1:0] func,
                               logic [mmts_pkg::DATA_W-1:0] value,
                               logic wait_idle);
        stack_request_t req;
        req.wait_idle = wait_idle;
        req.func      = func;
        req.value     = value;
        requests_to_send.push_back(req);
        if (func == mmts_pkg::FN_PUSH && gen_depth < mmts_pkg::STACK_DEPTH)
            gen_depth++;
        else if (func == mmts_pkg::FN_POP && gen_depth > 0)
            gen_depth--;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready)
                awaited_answers.push_back(apply_request(in_flight));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (requests_to_send.size() != 0 &&
                             !(requests_to_send[0].wait_idle && awaited_answers.size() != 0)) begin
                    in_flight = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= in_flight.value;
                    s_tuser  <= {{(8-mmts_pkg::FUNC_W){1'b0}}, in_flight.func};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            ready_cycle++;
            if (ready_cycle % 256 == 0)
                ready_mode = $urandom_range(0, 2);
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (ready_cycle % 23) < 15;
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_answers.size() == 0) begin
                $error("unexpected transfer: read_value %h status %0d",
                       m_tdata, m_tuser[mmts_pkg::STATUS_W-1:0]);
                mismatch_count++;
            end else begin
                seen_answer = awaited_answers.pop_front();
                if (m_tdata !== seen_answer.read_value) begin
                    $error("read_value: expected %h, got %h", seen_answer.read_value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[mmts_pkg::STATUS_W-1:0] !== seen_answer.status) begin
                    $error("status: expected %0d, got %0d",
                           seen_answer.status, m_tuser[mmts_pkg::STATUS_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        // empty-stack errors and unused codes
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_TOP, '0, 1'b0);
        add_request(mmts_pkg::FN_MAX, '1, 1'b0);
        add_request(mmts_pkg::FN_MIN, '0, 1'b0);
        add_request(3'd5, '1, 1'b0);
        add_request(3'd7, 32'h5a5a_a5a5, 1'b0);
        // extremes and ties as new records
        add_request(mmts_pkg::FN_PUSH, 32'h7fff_ffff, 1'b0);
        add_request(mmts_pkg::FN_PUSH, 32'h8000_0000, 1'b0);
        add_request(mmts_pkg::FN_MAX, '0, 1'b0);
        add_request(mmts_pkg::FN_MIN, '0, 1'b0);
        add_request(mmts_pkg::FN_PUSH, 32'h8000_0000, 1'b0);
        add_request(mmts_pkg::FN_PUSH, 32'h7fff_ffff, 1'b0);
        add_request(mmts_pkg::FN_TOP, '0, 1'b0);
        add_request(3'd6, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_MAX, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_MIN, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_TOP, '0, 1'b0);
        add_request(mmts_pkg::FN_PUSH, '1, 1'b1);
        add_request(mmts_pkg::FN_MIN, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);
        add_request(mmts_pkg::FN_POP, '0, 1'b0);

        // shallow stack: frequent underflow and empty reads
        repeat (200)
            add_request(random_func(40, 35), random_value(), 1'b0);
        // fill to capacity, then overflow
        while (gen_depth < mmts_pkg::STACK_DEPTH)
            add_request(random_func(85, 0), random_value(), 1'b0);
        add_request(mmts_pkg::FN_PUSH, random_value(), 1'b1);
        add_request(mmts_pkg::FN_PUSH, random_value(), 1'b0);
        add_request(mmts_pkg::FN_MAX, '0, 1'b0);
        add_request(mmts_pkg::FN_MIN, '0, 1'b0);
        add_request(mmts_pkg::FN_TOP, '0, 1'b0);
        // unwind through the record stacks
        add_request(mmts_pkg::FN_POP, '0, 1'b1);
        repeat (250)
            add_request(random_func(25, 55), random_value(), 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_to_send.size() != 0 || s_tvalid || awaited_answers.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mmts_pkg.sv
hdl/mmts_ctrl.sv
hdl/mmts_datapath.sv
hdl/min_max_tracking_stack.sv
dv/min_max_tracking_stack_tb.sv
